>>> rtl/itf_pkg.sv
// Shared constants, types and helper functions of the integer-to-text formatter.
// Used by the digit unit, the top level and the testbench; depends on nothing.
package itf_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int MAX_FIELD   = 60;
    localparam int MAX_RESULTS = 63;

    // Digit counts per radix for a VALUE_BITS-bit magnitude
    localparam int ND_BIN = VALUE_BITS;
    localparam int ND_OCT = (VALUE_BITS + 2) / 3;
    localparam int ND_HEX = (VALUE_BITS + 3) / 4;
    localparam int ND_DEC = ((VALUE_BITS * 1233) >> 12) + 1;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    localparam int DIG_W  = imax(imax(ND_BIN, 3 * ND_OCT), imax(4 * ND_HEX, 4 * ND_DEC));
    localparam int CNT_W  = $clog2(DIG_W + 1);
    localparam int LEFT_W = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] RADIX_BIN = 2'd0;
    localparam logic [1:0] RADIX_OCT = 2'd1;
    localparam logic [1:0] RADIX_DEC = 2'd2;
    localparam logic [1:0] RADIX_HEX = 2'd3;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LX    = 8'h78;

    typedef struct packed {
        logic                  load;
        logic [1:0]            radix;
        logic [VALUE_BITS-1:0] mag;
        logic                  take;
    } dig_cmd_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] count;
        logic [3:0]       top;
    } dig_stat_t;

    function automatic logic [5:0] sat_field(input logic [5:0] v);
        return (v > 6'(MAX_FIELD)) ? 6'(MAX_FIELD) : v;
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
        logic [7:0] base;
        base = lower ? CH_LA : CH_UA;
        if (d < 4'd10)
            return CH_ZERO + 8'(d);
        else
            return base + 8'(d) - 8'd10;
    endfunction

endpackage

>>> rtl/itf_req_if.sv
// Request channel of the integer-to-text formatter: one conversion per transaction.
// Standalone; valid/ready handshake with the request payload.
interface itf_req_if;
    logic       valid;
    logic       ready;
    logic [31:0] value;
    logic       num_signed;
    logic [1:0] radix_sel;
    logic       left_justify;
    logic       force_plus;
    logic       space_sign;
    logic       zero_fill;
    logic       alt_prefix;
    logic       lower_hex;
    logic [5:0] field_width;
    logic [5:0] min_digits;

    modport source (
        output valid, value, num_signed, radix_sel, left_justify, force_plus,
               space_sign, zero_fill, alt_prefix, lower_hex, field_width, min_digits,
        input  ready
    );
    modport sink (
        input  valid, value, num_signed, radix_sel, left_justify, force_plus,
               space_sign, zero_fill, alt_prefix, lower_hex, field_width, min_digits,
        output ready
    );
endinterface

>>> rtl/itf_char_if.sv
// Character channel of the integer-to-text formatter: one character per transaction.
// Standalone; valid/ready handshake with the character payload.
interface itf_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_char;

    modport source (
        output valid, out_char, last_char,
        input  ready
    );
    modport sink (
        input  valid, out_char, last_char,
        output ready
    );
endinterface

>>> rtl/itf_digit_unit.sv
// Digit unit: bit-serial binary-to-BCD conversion, leading-zero strip and digit shift-out.
// Depends on itf_pkg.
module itf_digit_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  itf_pkg::dig_cmd_t  cmd,
    output itf_pkg::dig_stat_t stat
);
    import itf_pkg::*;

    typedef enum logic [1:0] {D_IDLE, D_CONV, D_NORM, D_DONE} dstate_t;

    dstate_t               st_reg, st_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [1:0]            radix_reg, radix_next;
    logic [DIG_W-1:0]      dig_reg, dig_next;
    logic [VALUE_BITS-1:0] bin_reg, bin_next;

    logic [3:0]       top_digit;
    logic [DIG_W-1:0] dig_shift;
    logic [DIG_W-1:0] dig_adj;
    logic [CNT_W-1:0] load_cnt;

    always_comb
    begin
        case (radix_reg)
            RADIX_BIN: top_digit = {3'b000, dig_reg[ND_BIN-1]};
            RADIX_OCT: top_digit = {1'b0, dig_reg[3*ND_OCT-1 -: 3]};
            RADIX_HEX: top_digit = dig_reg[4*ND_HEX-1 -: 4];
            default:   top_digit = dig_reg[4*ND_DEC-1 -: 4];
        endcase
    end

    always_comb
    begin
        case (radix_reg)
            RADIX_BIN: dig_shift = dig_reg << 1;
            RADIX_OCT: dig_shift = dig_reg << 3;
            default:   dig_shift = dig_reg << 4;
        endcase
    end

    // add 3 to every BCD digit of 5 or more before the next shift
    always_comb
    begin
        dig_adj = dig_reg;
        for (int i = 0; i < ND_DEC; i++)
        begin
            if (dig_reg[4*i +: 4] >= 4'd5)
                dig_adj[4*i +: 4] = dig_reg[4*i +: 4] + 4'd3;
        end
    end

    always_comb
    begin
        case (cmd.radix)
            RADIX_BIN: load_cnt = CNT_W'(ND_BIN);
            RADIX_OCT: load_cnt = CNT_W'(ND_OCT);
            default:   load_cnt = CNT_W'(ND_HEX);
        endcase
    end

    always_comb
    begin
        st_next    = st_reg;
        cnt_next   = cnt_reg;
        radix_next = radix_reg;
        dig_next   = dig_reg;
        bin_next   = bin_reg;
        if (cmd.load)
        begin
            radix_next = cmd.radix;
            if (cmd.radix == RADIX_DEC)
            begin
                bin_next = cmd.mag;
                dig_next = '0;
                cnt_next = CNT_W'(VALUE_BITS);
                st_next  = D_CONV;
            end
            else
            begin
                dig_next = DIG_W'(cmd.mag);
                cnt_next = load_cnt;
                st_next  = D_NORM;
            end
        end
        else
        begin
            case (st_reg)
                D_CONV:
                begin
                    dig_next = {dig_adj[DIG_W-2:0], bin_reg[VALUE_BITS-1]};
                    bin_next = bin_reg << 1;
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                    begin
                        cnt_next = CNT_W'(ND_DEC);
                        st_next  = D_NORM;
                    end
                end
                D_NORM:
                begin
                    // drop leading zero digits, keep at least one
                    if (cnt_reg > CNT_W'(1) && top_digit == 4'd0)
                    begin
                        dig_next = dig_shift;
                        cnt_next = cnt_reg - 1'b1;
                    end
                    else
                        st_next = D_DONE;
                end
                D_DONE:
                begin
                    if (cmd.take)
                    begin
                        dig_next = dig_shift;
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= D_IDLE;
            cnt_reg   <= '0;
            radix_reg <= RADIX_DEC;
        end
        else
        begin
            st_reg    <= st_next;
            cnt_reg   <= cnt_next;
            radix_reg <= radix_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg <= dig_next;
        bin_reg <= bin_next;
    end

    assign stat.done  = (st_reg == D_DONE);
    assign stat.count = cnt_reg;
    assign stat.top   = top_digit;

    a_take_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take && !cmd.load |-> st_reg == D_DONE && cnt_reg != '0)
        else $error("digit taken with none left");

    a_bcd_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == D_DONE && radix_reg == RADIX_DEC && cnt_reg != '0 |-> top_digit <= 4'd9)
        else $error("decimal digit out of range");

    a_conv_to_norm: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == D_CONV && cnt_reg == CNT_W'(1) && !cmd.load
        |=> st_reg == D_NORM && cnt_reg == CNT_W'(ND_DEC))
        else $error("conversion did not hand over to normalization");

endmodule

>>> rtl/integer_to_text_formatter.sv
// Top level of the integer-to-text formatter: request decode, field arithmetic, text output.
// Depends on itf_pkg, itf_req_if, itf_char_if and itf_digit_unit.
//
//   channel  modport  transaction   payload
//   req      sink     one request   value, num_signed, radix_sel, flags, field_width, min_digits
//   text     source   one character out_char, last_char (set on the final character)
//
// A request passes through acceptance, bit-serial BCD conversion (decimal only), a strip
// step per leading zero digit (up to digits - 1) plus one to end the strip, a handoff,
// field arithmetic in ST_CALC and ST_SUM, then one character per cycle (at most
// MAX_RESULTS) while text is not stalled.
// The next request is taken once the final character sits in the output register.
// Reset is asynchronous, active low; no clearing pass follows it.
// A stall on text holds the output register and freezes character generation.
module integer_to_text_formatter (
    input logic       clk,
    input logic       rst_n,
    itf_req_if.sink   req,
    itf_char_if.source text
);
    import itf_pkg::*;

    typedef enum logic [2:0] {ST_IDLE, ST_DIGITS, ST_CALC, ST_SUM, ST_EMIT} state_t;

    state_t            state_reg, state_next;
    logic [1:0]        pre_cnt_reg, pre_cnt_next;
    logic              pre_two_reg, pre_two_next;
    logic [1:0]        radix_reg, radix_next;
    logic              lower_reg, lower_next;
    logic              left_j_reg, left_j_next;
    logic              zero_reg, zero_next;
    logic              sign_pend_reg, sign_pend_next;
    logic [7:0]        sign_ch_reg, sign_ch_next;
    logic [5:0]        wid_reg, wid_next;
    logic [5:0]        prec_reg, prec_next;
    logic [5:0]        zeros_reg, zeros_next;
    logic [5:0]        pad_reg, pad_next;
    logic [LEFT_W-1:0] left_reg, left_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_char_reg, out_char_next;
    logic              out_last_reg, out_last_next;

    dig_cmd_t  dcmd;
    dig_stat_t dstat;

    logic [VALUE_BITS-1:0] num;
    logic                  neg;
    logic                  accept;
    logic                  emit_step;
    logic [1:0]            pre_len;
    logic [5:0]            wid_sat;
    logic [7:0]            nd8, prec8, wid8, mx8, fill8, need8, tot8;

    itf_digit_unit u_digits (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (dcmd),
        .stat (dstat)
    );

    assign accept    = req.valid && req.ready;
    assign emit_step = !out_valid_reg || text.ready;

    assign num = VALUE_BITS'(req.value);
    assign neg = req.num_signed && (req.radix_sel == RADIX_DEC) && num[VALUE_BITS-1];

    assign pre_len = (req.alt_prefix && req.radix_sel != RADIX_DEC)
                   ? ((req.radix_sel == RADIX_OCT) ? 2'd1 : 2'd2) : 2'd0;
    assign wid_sat = sat_field(req.field_width);

    // field arithmetic on narrow counts
    assign nd8   = 8'(dstat.count);
    assign prec8 = {2'b00, prec_reg};
    assign wid8  = {2'b00, wid_reg};
    assign mx8   = (prec8 > nd8) ? prec8 : nd8;
    assign fill8 = (zero_reg && wid8 > prec8) ? wid8 : prec8;
    assign need8 = mx8 + {7'd0, sign_pend_reg};
    assign tot8  = {6'd0, pre_cnt_reg} + {7'd0, sign_pend_reg} + {2'b00, pad_reg}
                 + {2'b00, zeros_reg} + nd8;

    always_comb
    begin
        dcmd.load  = accept;
        dcmd.radix = req.radix_sel;
        dcmd.mag   = neg ? (~num + 1'b1) : num;
        dcmd.take  = 1'b0;

        state_next     = state_reg;
        pre_cnt_next   = pre_cnt_reg;
        pre_two_next   = pre_two_reg;
        radix_next     = radix_reg;
        lower_next     = lower_reg;
        left_j_next    = left_j_reg;
        zero_next      = zero_reg;
        sign_pend_next = sign_pend_reg;
        sign_ch_next   = sign_ch_reg;
        wid_next       = wid_reg;
        prec_next      = prec_reg;
        zeros_next     = zeros_reg;
        pad_next       = pad_reg;
        left_next      = left_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !text.ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pre_cnt_next   = pre_len;
                    pre_two_next   = (req.radix_sel != RADIX_OCT);
                    radix_next     = req.radix_sel;
                    lower_next     = req.lower_hex;
                    left_j_next    = req.left_justify;
                    zero_next      = req.zero_fill;
                    sign_pend_next = neg || req.force_plus || req.space_sign;
                    sign_ch_next   = neg ? CH_MINUS : (req.space_sign ? CH_SPACE : CH_PLUS);
                    wid_next       = (wid_sat > {4'd0, pre_len}) ? wid_sat - {4'd0, pre_len}
                                                                 : 6'd0;
                    prec_next      = sat_field(req.min_digits);
                    state_next     = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (dstat.done)
                    state_next = ST_CALC;
            end
            ST_CALC:
            begin
                zeros_next = (fill8 > nd8) ? 6'(fill8 - nd8) : 6'd0;
                pad_next   = (!zero_reg && wid8 > need8) ? 6'(wid8 - need8) : 6'd0;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                left_next  = (tot8 > 8'(MAX_RESULTS)) ? LEFT_W'(MAX_RESULTS) : LEFT_W'(tot8);
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_step)
                begin
                    if (pre_cnt_reg != 2'd0)
                    begin
                        if (pre_cnt_reg == 2'd2 || !pre_two_reg)
                            out_char_next = CH_ZERO;
                        else if (radix_reg == RADIX_HEX)
                            out_char_next = lower_reg ? CH_LX : CH_UX;
                        else
                            out_char_next = CH_LB;
                        pre_cnt_next = pre_cnt_reg - 1'b1;
                    end
                    else if (sign_pend_reg)
                    begin
                        out_char_next  = sign_ch_reg;
                        sign_pend_next = 1'b0;
                    end
                    else if (!left_j_reg && pad_reg != 6'd0)
                    begin
                        out_char_next = CH_SPACE;
                        pad_next      = pad_reg - 1'b1;
                    end
                    else if (zeros_reg != 6'd0)
                    begin
                        out_char_next = CH_ZERO;
                        zeros_next    = zeros_reg - 1'b1;
                    end
                    else if (dstat.count != '0)
                    begin
                        out_char_next = digit_char(dstat.top, lower_reg);
                        dcmd.take     = 1'b1;
                    end
                    else
                    begin
                        out_char_next = CH_SPACE;
                        pad_next      = pad_reg - 1'b1;
                    end
                    out_valid_next = 1'b1;
                    out_last_next  = (left_reg == LEFT_W'(1));
                    left_next      = left_reg - 1'b1;
                    // drop whatever is left once the character budget is spent
                    if (left_reg == LEFT_W'(1))
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pre_cnt_reg   <= 2'd0;
            pre_two_reg   <= 1'b0;
            radix_reg     <= RADIX_DEC;
            lower_reg     <= 1'b0;
            left_j_reg    <= 1'b0;
            zero_reg      <= 1'b0;
            sign_pend_reg <= 1'b0;
            sign_ch_reg   <= CH_PLUS;
            wid_reg       <= 6'd0;
            prec_reg      <= 6'd0;
            zeros_reg     <= 6'd0;
            pad_reg       <= 6'd0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_char_reg  <= CH_SPACE;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pre_cnt_reg   <= pre_cnt_next;
            pre_two_reg   <= pre_two_next;
            radix_reg     <= radix_next;
            lower_reg     <= lower_next;
            left_j_reg    <= left_j_next;
            zero_reg      <= zero_next;
            sign_pend_reg <= sign_pend_next;
            sign_ch_reg   <= sign_ch_next;
            wid_reg       <= wid_next;
            prec_reg      <= prec_next;
            zeros_reg     <= zeros_next;
            pad_reg       <= pad_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
            out_char_reg  <= out_char_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign req.ready      = (state_reg == ST_IDLE);
    assign text.valid     = out_valid_reg;
    assign text.out_char  = out_char_reg;
    assign text.last_char = out_last_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req.ready)
        else $error("request taken while a conversion is in flight");

    a_budget_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> left_reg != '0)
        else $error("emitting with an empty character budget");

    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT && emit_step && left_reg == LEFT_W'(1)
        |=> state_reg == ST_IDLE && text.valid && text.last_char)
        else $error("final character did not close the conversion");

endmodule

>>> test/integer_to_text_formatter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of integer_to_text_formatter: predicts the formatted text of each
// request and compares every character and end-of-text flag. Needs itf_pkg and the interfaces.
module integer_to_text_formatter_tb;
    import itf_pkg::*;

    localparam logic [5:0] F_LEFT  = 6'b100000;
    localparam logic [5:0] F_PLUS  = 6'b010000;
    localparam logic [5:0] F_SPACE = 6'b001000;
    localparam logic [5:0] F_ZERO  = 6'b000100;
    localparam logic [5:0] F_ALT   = 6'b000010;
    localparam logic [5:0] F_LOWER = 6'b000001;

    localparam int RANDOM_REQS  = 460;
    localparam int HOLD_AT_REQ  = 300;
    localparam int HOLD_CYCLES  = 3000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic [31:0] value;
        logic        num_signed;
        logic [1:0]  radix;
        logic [5:0]  flags;
        logic [5:0]  width;
        logic [5:0]  prec;
    } conv_req_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_beat_t;

    logic clk;
    logic rst_n;

    itf_req_if  req();
    itf_char_if text();

    integer_to_text_formatter dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .text  (text)
    );

    conv_req_t  pending_reqs[$];
    text_beat_t expected_text[$];

    int   total_reqs = 0;
    int   reqs_taken = 0;
    int   chars_checked = 0;
    int   conversions_done = 0;
    int   longest_text = 0;
    int   error_count = 0;
    logic req_fire = 1'b0;
    int   burst_left = 0;
    int   gap_left = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;
    int   rx_mode = 0;
    logic [7:0] rx_phase = 8'd0;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= 40)
            $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    task automatic queue_req(input logic [31:0] v, input logic sgn, input logic [1:0] rdx,
                             input logic [5:0] flags, input logic [5:0] w, input logic [5:0] p);
        conv_req_t r;
        r.value      = v;
        r.num_signed = sgn;
        r.radix      = rdx;
        r.flags      = flags;
        r.width      = w;
        r.prec       = p;
        pending_reqs.push_back(r);
    endtask

    // Build the text of one conversion and append its characters to expected_text.
    function automatic void format_expected(input conv_req_t r);
        int          width;
        int          prec;
        int          base;
        int          ndig;
        int          pad;
        int          n;
        int          i;
        logic [31:0] mag;
        logic [7:0]  sign_ch;
        logic        emit_sign;
        logic        lower;
        logic [7:0]  rev [0:63];
        logic [7:0]  chars [$];
        string       digit_set;
        text_beat_t  beat;

        width = (r.width > MAX_FIELD) ? MAX_FIELD : int'(r.width);
        prec  = (r.prec > MAX_FIELD) ? MAX_FIELD : int'(r.prec);
        lower = (r.flags & F_LOWER) != 0;
        digit_set = lower ? "0123456789abcdef" : "0123456789ABCDEF";
        case (r.radix)
            RADIX_BIN: base = 2;
            RADIX_OCT: base = 8;
            RADIX_DEC: base = 10;
            default:   base = 16;
        endcase
        emit_sign = (r.flags & (F_PLUS | F_SPACE)) != 0;
        sign_ch   = ((r.flags & F_SPACE) != 0) ? CH_SPACE : CH_PLUS;
        mag       = r.value;

        // prefix eats into the width, never below zero
        if ((r.flags & F_ALT) != 0 && r.radix != RADIX_DEC) begin
            chars.push_back(CH_ZERO);
            if (width > 0)
                width--;
            if (r.radix != RADIX_OCT) begin
                chars.push_back(r.radix == RADIX_BIN ? CH_LB : (lower ? CH_LX : CH_UX));
                if (width > 0)
                    width--;
            end
        end

        if (r.num_signed && r.radix == RADIX_DEC && mag[VALUE_BITS-1]) begin
            mag       = -mag;
            sign_ch   = CH_MINUS;
            emit_sign = 1'b1;
        end

        ndig = 0;
        while (mag != 0) begin
            rev[ndig] = digit_set[int'(mag % base)];
            mag = mag / base;
            ndig++;
        end
        if (ndig == 0) begin
            rev[0] = CH_ZERO;
            ndig   = 1;
        end

        pad = width - ((prec > ndig) ? prec : ndig);
        if ((r.flags & F_ZERO) != 0) begin
            pad = 0;
            if (width > prec)
                prec = width;
        end

        if (emit_sign) begin
            chars.push_back(sign_ch);
            pad--;
        end
        if ((r.flags & F_LEFT) == 0)
            for (i = 0; i < pad; i++)
                chars.push_back(CH_SPACE);
        for (i = ndig; i < prec; i++)
            chars.push_back(CH_ZERO);
        for (i = ndig - 1; i >= 0; i--)
            chars.push_back(rev[i]);
        if ((r.flags & F_LEFT) != 0)
            for (i = 0; i < pad; i++)
                chars.push_back(CH_SPACE);

        // drop anything past the output limit; the flag marks the last kept character
        n = (chars.size() > MAX_RESULTS) ? MAX_RESULTS : chars.size();
        for (i = 0; i < n; i++) begin
            beat.ch   = chars[i];
            beat.last = (i == n - 1);
            expected_text.push_back(beat);
        end
        if (n > longest_text)
            longest_text = n;
    endfunction

    // Monitor: predict on each accepted request, check each accepted character.
    always @(posedge clk) begin
        text_beat_t beat;
        conv_req_t  r;
        if (rst_n) begin
            req_fire <= req.valid && req.ready;
            if (req.valid && req.ready) begin
                r.value      = req.value;
                r.num_signed = req.num_signed;
                r.radix      = req.radix_sel;
                r.flags      = {req.left_justify, req.force_plus, req.space_sign,
                                req.zero_fill, req.alt_prefix, req.lower_hex};
                r.width      = req.field_width;
                r.prec       = req.min_digits;
                format_expected(r);
                reqs_taken <= reqs_taken + 1;
            end
            if (text.valid && text.ready) begin
                if (expected_text.size() == 0) begin
                    report_mismatch($sformatf("unexpected character 0x%02h", text.out_char));
                end
                else begin
                    beat = expected_text.pop_front();
                    if (text.out_char !== beat.ch)
                        report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
                                                  text.out_char, beat.ch));
                    if (text.last_char !== beat.last)
                        report_mismatch($sformatf("last_char %b, expected %b on char 0x%02h",
                                                  text.last_char, beat.last, beat.ch));
                    chars_checked++;
                    if (text.last_char)
                        conversions_done++;
                end
            end
        end
    end

    // Request driver: random-length bursts, random gaps; none for requests 100 to 179.
    always @(negedge clk) begin
        conv_req_t item;
        logic      no_gaps;
        no_gaps = (reqs_taken >= 100 && reqs_taken < 180);
        if (!rst_n) begin
            req.valid <= 1'b0;
        end
        else if (req.valid && !req_fire) begin
            // hold the offered transaction
        end
        else if (gap_left > 0) begin
            gap_left  <= gap_left - 1;
            req.valid <= 1'b0;
        end
        else if (pending_reqs.size() > 0) begin
            item = pending_reqs.pop_front();
            req.value        <= item.value;
            req.num_signed   <= item.num_signed;
            req.radix_sel    <= item.radix;
            req.left_justify <= (item.flags & F_LEFT) != 0;
            req.force_plus   <= (item.flags & F_PLUS) != 0;
            req.space_sign   <= (item.flags & F_SPACE) != 0;
            req.zero_fill    <= (item.flags & F_ZERO) != 0;
            req.alt_prefix   <= (item.flags & F_ALT) != 0;
            req.lower_hex    <= (item.flags & F_LOWER) != 0;
            req.field_width  <= item.width;
            req.min_digits   <= item.prec;
            req.valid        <= 1'b1;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 12);
                if (no_gaps)
                    gap_left <= 0;
                else if ($urandom_range(0, 3) == 0)
                    gap_left <= $urandom_range(20, 120);
                else
                    gap_left <= $urandom_range(0, 6);
            end
            else begin
                burst_left <= burst_left - 1;
            end
        end
        else begin
            req.valid <= 1'b0;
        end
    end

    // Long receiver hold-off: the block fills and must stall its request input.
    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_left > 0)
                hold_left <= hold_left - 1;
            else if (!hold_done && reqs_taken >= HOLD_AT_REQ) begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end
        end
    end

    // Receiver: stall pattern is drawn anew each time the 8-bit phase counter wraps.
    always @(negedge clk) begin
        logic go;
        if (!rst_n) begin
            text.ready <= 1'b0;
        end
        else begin
            rx_phase <= rx_phase + 8'd1;
            if (rx_phase == 8'd0)
                rx_mode <= $urandom_range(0, 4);
            case (rx_mode)
                0:       go = 1'b1;
                1:       go = 1'($urandom_range(0, 1));
                2:       go = ($urandom_range(0, 7) != 0);
                3:       go = (rx_phase[1:0] == 2'b00);
                default: go = ($urandom_range(0, 15) == 0);
            endcase
            text.ready <= go && (hold_left == 0);
        end
    end

    initial begin
        int          k;
        logic [31:0] v;
        logic [5:0]  w;
        logic [5:0]  p;

        rst_n            = 1'b0;
        req.valid        = 1'b0;
        req.value        = '0;
        req.num_signed   = 1'b0;
        req.radix_sel    = RADIX_BIN;
        req.left_justify = 1'b0;
        req.force_plus   = 1'b0;
        req.space_sign   = 1'b0;
        req.zero_fill    = 1'b0;
        req.alt_prefix   = 1'b0;
        req.lower_hex    = 1'b0;
        req.field_width  = '0;
        req.min_digits   = '0;
        text.ready       = 1'b0;

        // zero in every radix, with and without prefix
        queue_req(32'd0, 1'b0, RADIX_DEC, 6'd0, 6'd0, 6'd0);
        queue_req(32'd0, 1'b0, RADIX_OCT, F_ALT, 6'd0, 6'd0);
        queue_req(32'd0, 1'b0, RADIX_HEX, F_ALT | F_LOWER, 6'd10, 6'd0);
        queue_req(32'd0, 1'b1, RADIX_DEC, F_LEFT | F_SPACE, 6'd0, 6'd0);
        queue_req(32'd0, 1'b0, RADIX_BIN, F_ALT | F_ZERO, 6'd8, 6'd0);
        // extremes of the value, signed and unsigned
        queue_req(32'hFFFF_FFFF, 1'b0, RADIX_DEC, 6'd0, 6'd0, 6'd0);
        queue_req(32'h8000_0000, 1'b1, RADIX_DEC, 6'd0, 6'd0, 6'd0);
        queue_req(32'hFFFF_FFFF, 1'b1, RADIX_DEC, F_PLUS, 6'd5, 6'd0);
        queue_req(32'h7FFF_FFFF, 1'b1, RADIX_DEC, F_ZERO | F_PLUS | F_LEFT, 6'd20, 6'd30);
        queue_req(32'h8000_0000, 1'b1, RADIX_OCT, F_ALT, 6'd0, 6'd0);
        // sign flags, space wins over plus
        queue_req(32'd123, 1'b1, RADIX_DEC, F_PLUS, 6'd8, 6'd0);
        queue_req(32'd123, 1'b0, RADIX_DEC, F_PLUS | F_SPACE | F_LEFT, 6'd8, 6'd0);
        queue_req(32'd7, 1'b0, RADIX_DEC, F_LEFT | F_SPACE, 6'd10, 6'd5);
        // hex case, signed non-decimal prints the raw pattern
        queue_req(32'hDEAD_BEEF, 1'b0, RADIX_HEX, F_ALT | F_ZERO, 6'd12, 6'd0);
        queue_req(32'hDEAD_BEEF, 1'b0, RADIX_HEX, F_ALT | F_LOWER, 6'd0, 6'd4);
        queue_req(32'hFFFF_FF00, 1'b1, RADIX_HEX, F_PLUS, 6'd0, 6'd0);
        queue_req(32'h0000_000A, 1'b0, RADIX_HEX, F_ALT, 6'd1, 6'd0);
        // saturated width and precision, longest text
        queue_req(32'hFFFF_FFFF, 1'b1, RADIX_BIN, F_ALT, 6'd63, 6'd0);
        queue_req(32'd5, 1'b0, RADIX_BIN, F_ALT | F_PLUS, 6'd0, 6'd63);
        queue_req(32'o777, 1'b0, RADIX_OCT, F_LEFT | F_ALT, 6'd63, 6'd61);
        queue_req(32'hFFFF_FFFF, 1'b0, RADIX_HEX, F_ZERO | F_PLUS, 6'd63, 6'd0);
        // width below text length, zero fill overriding left justify, lower case on octal
        queue_req(32'd1234567, 1'b0, RADIX_DEC, 6'd0, 6'd3, 6'd2);
        queue_req(32'hFFFF_FFD6, 1'b1, RADIX_DEC, F_ZERO | F_LEFT, 6'd10, 6'd0);
        queue_req(32'o17, 1'b0, RADIX_OCT, F_LOWER | F_SPACE, 6'd6, 6'd0);

        for (k = 0; k < RANDOM_REQS; k++) begin
            case ($urandom_range(0, 5))
                0:       v = $urandom;
                1:       v = $urandom_range(0, 20);
                2:       v = 32'hFFFF_FFFF - $urandom_range(0, 20);
                3:       v = 32'h8000_0000 + $urandom_range(0, 3);
                4:       v = 32'h7FFF_FFFF - $urandom_range(0, 3);
                default: v = 32'd1 << $urandom_range(0, 31);
            endcase
            // mostly short fields; full range now and then
            w = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(0, 10));
            p = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(0, 10));
            queue_req(v, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                      6'($urandom_range(0, 63)), w, p);
        end
        total_reqs = pending_reqs.size();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (reqs_taken < total_reqs || expected_text.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d conversions (%0d characters, longest %0d) in all radices and flags",
                 conversions_done, chars_checked, longest_text);
        $display("Receiver held off for %0d cycles with requests still offered", HOLD_CYCLES);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #100_000_000;
        $display("Timeout with %0d of %0d requests taken", reqs_taken, total_reqs);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
